### design/tcw_pkg.sv
// tcw_pkg: shared constants, codes and types of the text console writer
// no dependencies; imported by the interfaces and by every tcw module
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // payload field widths
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int COLUMN_W   = 7;
  localparam int ROWNUM_W   = 5;
  localparam int CELL_W     = 16;
  localparam int OFFSET_W   = 11;
  localparam int FILL_W     = 7;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_FILL_COLOR = 1'b0;
  localparam logic [FILL_W-1:0] FILL_RESET = 7'd7;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SET   = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_RDWAIT,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

### design/tcw_in_if.sv
// tcw_in_if: input item channel (valid/ready plus command payload)
// depends on tcw_pkg for field widths
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  color;
  logic [COLUMN_W-1:0] column;
  logic [ROWNUM_W-1:0] row;

  modport source (output valid, mode, char_code, color, column, row, input ready);
  modport sink   (input valid, mode, char_code, color, column, row, output ready);
endinterface

`default_nettype wire

### design/tcw_out_if.sv
// tcw_out_if: result channel (valid/ready plus cell and cursor payload)
// depends on tcw_pkg for field widths
`default_nettype none

interface tcw_out_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CELL_W-1:0]   cell_word;
  logic [COLUMN_W-1:0] cursor_col;
  logic [ROWNUM_W-1:0] cursor_row;
  logic [OFFSET_W-1:0] cursor_offset;
  logic                scrolled;

  modport source (output valid, cell_word, cursor_col, cursor_row, cursor_offset, scrolled,
                  input ready);
  modport sink   (input valid, cell_word, cursor_col, cursor_row, cursor_offset, scrolled,
                  output ready);
endinterface

`default_nettype wire

### design/tcw_mem.sv
// tcw_mem: screen store, one write port and one registered read port
// depends on tcw_pkg for the cell width
`default_nettype none

module tcw_mem import tcw_pkg::*; #(
  parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [CELL_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/tcw_ctrl.sv
// tcw_ctrl: sequencer, cursor state, shared offset unit and sweep counter
// depends on tcw_pkg, tcw_in_if, tcw_out_if; drives the tcw_mem ports
`default_nettype none

module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int ADDR_W  = $clog2(CELLS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [FILL_W-1:0] fill_i,
  tcw_in_if.sink                 item_i,
  tcw_out_if.source              result_o,
  output logic                   mem_we_o,
  output logic      [ADDR_W-1:0] mem_waddr_o,
  output logic      [CELL_W-1:0] mem_wdata_o,
  output logic                   mem_re_o,
  output logic      [ADDR_W-1:0] mem_raddr_o,
  input  wire logic [CELL_W-1:0] mem_rdata_i
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int MOVE  = CELLS - COLUMNS;

  localparam logic [COL_W:0]   COLS_LIM = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROWS_LIM = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(ROWS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] CNT_MOVE = CNT_W'(MOVE);

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic [COLOR_W-1:0]  color_q, color_d;
  logic [COLUMN_W-1:0] col_in_q, col_in_d;
  logic [ROWNUM_W-1:0] row_in_q, row_in_d;
  logic [COL_W-1:0]    cur_col_q, cur_col_d;
  logic [ROW_W-1:0]    cur_row_q, cur_row_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic                scrolled_q, scrolled_d;

  logic                out_valid_q, out_valid_d;
  logic [CELL_W-1:0]   out_cell_q, out_cell_d;
  logic [COLUMN_W-1:0] out_col_q, out_col_d;
  logic [ROWNUM_W-1:0] out_row_q, out_row_d;
  logic [OFFSET_W-1:0] out_off_q, out_off_d;
  logic                out_scr_q, out_scr_d;

  // shared offset unit: row * COLUMNS + col
  logic [COL_W-1:0]  op_col;
  logic [ROW_W-1:0]  op_row;
  logic [31:0]       prod;
  logic [ADDR_W-1:0] op_addr;

  // clamped target position
  logic [31:0]      col_t32, row_t32;
  logic [COL_W-1:0] col_clamp;
  logic [ROW_W-1:0] row_clamp;

  // put character next-cursor helpers
  logic [COL_W:0]   col_next;
  logic [ROW_W:0]   row_next;
  logic             is_nl, is_bs;

  // sweep helpers
  logic [31:0]       rd_sum;
  logic [CNT_W-1:0]  idx_prev;
  logic [CELL_W-1:0] blank;
  logic [31:0]       col_o32, row_o32, off_o32;

  logic in_xfer, out_xfer;

  assign in_xfer  = item_i.valid && item_i.ready;
  assign out_xfer = result_o.valid && result_o.ready;

  assign blank = {1'b0, fill_i, CH_SPACE};

  assign col_t32   = (32'(col_in_q) > 32'(COLUMNS - 1)) ? 32'(COLUMNS - 1) : 32'(col_in_q);
  assign row_t32   = (32'(row_in_q) > 32'(ROWS - 1)) ? 32'(ROWS - 1) : 32'(row_in_q);
  assign col_clamp = col_t32[COL_W-1:0];
  assign row_clamp = row_t32[ROW_W-1:0];

  assign is_nl = (char_q == CH_NEWLINE);
  assign is_bs = (char_q == CH_BACKSPACE);

  // operand select for the offset unit
  always_comb begin
    op_col = cur_col_q;
    op_row = cur_row_q;
    if (state_q == ST_EXEC) begin
      if (mode_q == MODE_READ) begin
        op_col = col_clamp;
        op_row = row_clamp;
      end else if (is_bs) begin
        op_col = cur_col_q - COL_W'(1);
      end
    end
  end

  assign prod    = 32'(op_row) * 32'(COLUMNS) + 32'(op_col);
  assign op_addr = prod[ADDR_W-1:0];

  assign rd_sum   = 32'(idx_q) + 32'(COLUMNS);
  assign idx_prev = idx_q - CNT_W'(1);

  assign col_o32 = 32'(cur_col_q);
  assign row_o32 = 32'(cur_row_q);
  assign off_o32 = 32'(op_addr);

  // state and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    char_q     <= char_d;
    color_q    <= color_d;
    col_in_q   <= col_in_d;
    row_in_q   <= row_in_d;
    cell_q     <= cell_d;
    scrolled_q <= scrolled_d;
    out_cell_q <= out_cell_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_off_q  <= out_off_d;
    out_scr_q  <= out_scr_d;
  end

  // next state, datapath and memory control
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    char_d      = char_q;
    color_d     = color_q;
    col_in_d    = col_in_q;
    row_in_d    = row_in_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    idx_d       = idx_q;
    cell_d      = cell_q;
    scrolled_d  = scrolled_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_cell_d  = out_cell_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_off_d   = out_off_q;
    out_scr_d   = out_scr_q;
    col_next    = {1'b0, cur_col_q};
    row_next    = {1'b0, cur_row_q};
    mem_we_o    = 1'b0;
    mem_waddr_o = op_addr;
    mem_wdata_o = {color_q, char_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = op_addr;
    item_i.ready = 1'b0;

    case (state_q)
      // zero the store after reset, one cell per cycle
      ST_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[ADDR_W-1:0];
        mem_wdata_o = '0;
        idx_d       = idx_q + CNT_W'(1);
        if (idx_q == CNT_LAST) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        item_i.ready = 1'b1;
        if (in_xfer) begin
          mode_d     = mode_e'(item_i.mode);
          char_d     = item_i.char_code;
          color_d    = item_i.color;
          col_in_d   = item_i.column;
          row_in_d   = item_i.row;
          cell_d     = '0;
          scrolled_d = 1'b0;
          state_d    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (mode_q)
          MODE_PUT: begin
            if (is_nl) begin
              col_next = '0;
              row_next = {1'b0, cur_row_q} + (ROW_W + 1)'(1);
            end else if (is_bs) begin
              if (cur_col_q != '0) begin
                col_next    = {1'b0, cur_col_q} - (COL_W + 1)'(1);
                mem_we_o    = 1'b1;
                mem_wdata_o = {color_q, CH_SPACE};
              end
            end else begin
              mem_we_o = 1'b1;
              col_next = {1'b0, cur_col_q} + (COL_W + 1)'(1);
            end
            // end of row wrap
            if (col_next >= COLS_LIM) begin
              col_next = '0;
              row_next = {1'b0, cur_row_q} + (ROW_W + 1)'(1);
            end
            cur_col_d = col_next[COL_W-1:0];
            if (row_next >= ROWS_LIM) begin
              cur_row_d  = ROW_MAX;
              scrolled_d = 1'b1;
              idx_d      = '0;
              state_d    = ST_SCROLL;
            end else begin
              cur_row_d = row_next[ROW_W-1:0];
              state_d   = ST_RESP;
            end
          end
          MODE_CLEAR: begin
            cur_col_d = '0;
            cur_row_d = '0;
            idx_d     = '0;
            state_d   = ST_CLEAR;
          end
          MODE_SET: begin
            cur_col_d = col_clamp;
            cur_row_d = row_clamp;
            state_d   = ST_RESP;
          end
          MODE_READ: begin
            mem_re_o = 1'b1;
            state_d  = ST_RDWAIT;
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end

      // fill every cell with a blank in the fill color
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[ADDR_W-1:0];
        mem_wdata_o = blank;
        idx_d       = idx_q + CNT_W'(1);
        if (idx_q == CNT_LAST) begin
          state_d = ST_RESP;
        end
      end

      // move each cell up one row and blank the bottom row: read one row below, write it in the next cycle
      ST_SCROLL: begin
        if (idx_q < CNT_MOVE) begin
          mem_re_o = 1'b1;
        end
        mem_raddr_o = rd_sum[ADDR_W-1:0];
        if (idx_q != '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_prev[ADDR_W-1:0];
          mem_wdata_o = (idx_q <= CNT_MOVE) ? mem_rdata_i : blank;
        end
        idx_d = idx_q + CNT_W'(1);
        if (idx_q == CNT_END) begin
          idx_d   = '0;
          state_d = ST_RESP;
        end
      end

      ST_RDWAIT: begin
        cell_d  = mem_rdata_i;
        state_d = ST_RESP;
      end

      // hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_q || out_xfer) begin
          out_valid_d = 1'b1;
          out_cell_d  = cell_q;
          out_col_d   = col_o32[COLUMN_W-1:0];
          out_row_d   = row_o32[ROWNUM_W-1:0];
          out_off_d   = off_o32[OFFSET_W-1:0];
          out_scr_d   = scrolled_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.cell_word     = out_cell_q;
  assign result_o.cursor_col    = out_col_q;
  assign result_o.cursor_row    = out_row_q;
  assign result_o.cursor_offset = out_off_q;
  assign result_o.scrolled      = out_scr_q;

endmodule

`default_nettype wire

### design/text_console_writer.sv
// text console writer: put char / newline / backspace, set cursor, read cell and clear screen
// items; clear screen and a put char that scrolls sweep over the whole screen store.
// one item at a time; the next item is taken while the previous result waits.
// after reset the store is zeroed with no item taken;
// cursor resets to 0,0 and fill_color to 7
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tcw_in_if.sink                 item_i,
  tcw_out_if.source              result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [FILL_W-1:0] fill_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  // fill color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FILL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FILL_COLOR) begin
      fill_q <= pwdata[FILL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FILL_COLOR) ? {{(APB_DW - FILL_W){1'b0}}, fill_q} : '0;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fill_i      (fill_q),
    .item_i      (item_i),
    .result_o    (result_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcw_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

### tb/tcw_screen_checker.sv
`timescale 1ns / 100ps
// tcw_screen_checker: mirrors the screen store, cursor and fill color of the console writer,
// predicts the result of every item transfer and compares it with the result transfers
// depends on tcw_pkg, tcw_in_if and tcw_out_if

module tcw_screen_checker import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_in_if                 item_i,
  tcw_out_if                result_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count_o,
  output int                reports_owed_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [APB_AW-1:0] FILL_ADDR = APB_AW'(4 * REG_FILL_COLOR);

  typedef struct packed {
    logic [CELL_W-1:0]   cell_word;
    logic [COLUMN_W-1:0] cursor_col;
    logic [ROWNUM_W-1:0] cursor_row;
    logic [OFFSET_W-1:0] cursor_offset;
    logic                scrolled;
  } cursor_report_t;

  // mirrored state of the console
  logic [CELL_W-1:0] screen_mirror [CELLS];
  int unsigned       cur_x;
  int unsigned       cur_y;
  logic [FILL_W-1:0] fill_attr;
  cursor_report_t    awaited_reports [$];

  // apply one item to the mirror and return the report it should produce
  function automatic cursor_report_t advance_console(mode_e mode, logic [CHAR_W-1:0] ch,
      logic [COLOR_W-1:0] attr, logic [COLUMN_W-1:0] x, logic [ROWNUM_W-1:0] y);
    cursor_report_t    r;
    logic [CELL_W-1:0] blank;
    int unsigned       cx;
    int unsigned       cy;
    r = '0;
    blank = {1'b0, fill_attr, CH_SPACE};
    cx = (x > COLUMNS - 1) ? COLUMNS - 1 : x;
    cy = (y > ROWS - 1) ? ROWS - 1 : y;
    case (mode)
      MODE_PUT: begin
        if (ch == CH_NEWLINE) begin
          cur_x = 0;
          cur_y++;
        end else if (ch == CH_BACKSPACE) begin
          // backspace blanks the previous cell, never moves past column 0
          if (cur_x > 0) begin
            cur_x--;
            screen_mirror[cur_y * COLUMNS + cur_x] = {attr, CH_SPACE};
          end
        end else begin
          screen_mirror[cur_y * COLUMNS + cur_x] = {attr, ch};
          cur_x++;
        end
        // wrap at the end of a row
        if (cur_x >= COLUMNS) begin
          cur_x = 0;
          cur_y++;
        end
        // past the last row: scroll up, bottom row gets fill blanks, column kept
        if (cur_y >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_mirror[i] = screen_mirror[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mirror[i] = blank;
          cur_y = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mirror[i] = blank;
        cur_x = 0;
        cur_y = 0;
      end
      MODE_SET: begin
        cur_x = cx;
        cur_y = cy;
      end
      default: begin
        r.cell_word = screen_mirror[cy * COLUMNS + cx];
      end
    endcase
    r.cursor_col    = COLUMN_W'(cur_x);
    r.cursor_row    = ROWNUM_W'(cur_y);
    r.cursor_offset = OFFSET_W'(cur_y * COLUMNS + cur_x);
    return r;
  endfunction

  function automatic int field_differs(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // watch config writes, result transfers and item transfers
  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t got;
    cursor_report_t want;
    int             errs;
    if (!rst_ni) begin
      foreach (screen_mirror[i]) screen_mirror[i] = '0;
      cur_x = 0;
      cur_y = 0;
      fill_attr = FILL_RESET;
      awaited_reports.delete();
      fail_count_o <= 0;
      reports_owed_o <= 0;
    end else begin
      errs = 0;
      if (psel && penable && pwrite && pready && paddr == FILL_ADDR) begin
        fill_attr = pwdata[FILL_W-1:0];
      end
      if (result_i.valid && result_i.ready) begin
        got.cell_word     = result_i.cell_word;
        got.cursor_col    = result_i.cursor_col;
        got.cursor_row    = result_i.cursor_row;
        got.cursor_offset = result_i.cursor_offset;
        got.scrolled      = result_i.scrolled;
        if (awaited_reports.size() == 0) begin
          $error("result transfer with no item outstanding");
          errs++;
        end else begin
          want = awaited_reports.pop_front();
          errs += field_differs("cell_word", 32'(want.cell_word), 32'(got.cell_word));
          errs += field_differs("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
          errs += field_differs("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
          errs += field_differs("cursor_offset", 32'(want.cursor_offset),
                                32'(got.cursor_offset));
          errs += field_differs("scrolled", 32'(want.scrolled), 32'(got.scrolled));
        end
      end
      if (item_i.valid && item_i.ready) begin
        awaited_reports.push_back(advance_console(mode_e'(item_i.mode), item_i.char_code,
                                                  item_i.color, item_i.column, item_i.row));
      end
      fail_count_o <= fail_count_o + errs;
      reports_owed_o <= awaited_reports.size();
    end
  end

endmodule

### tb/text_console_writer_tb.sv
`timescale 1ns / 100ps
// text_console_writer_tb: drives items, fill color writes and result stalls into the
// console writer and reports the verdict; depends on tcw_pkg, the interfaces, the RTL
// and tcw_screen_checker

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam logic [APB_AW-1:0] FILL_ADDR = APB_AW'(4 * REG_FILL_COLOR);
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 138;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                reports_owed;
  bit                src_idle_en;
  bit                sink_stall_en;
  int                items_sent;
  int                fill_settings;

  tcw_in_if  item_if ();
  tcw_out_if result_if ();

  text_console_writer #(.COLUMNS(COLUMNS_DEF), .ROWS(ROWS_DEF)) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tcw_screen_checker #(.COLUMNS(COLUMNS_DEF), .ROWS(ROWS_DEF)) u_screen_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_if),
    .result_i       (result_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count_o   (fail_count),
    .reports_owed_o (reports_owed)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // worst case is every item a full-screen sweep plus both idle bursts, taken many times over
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stall bursts while enabled
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
    end
  end

  // one item transfer, with an optional idle burst ahead of it
  task automatic send_item(mode_e m, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] attr,
                           logic [COLUMN_W-1:0] x, logic [ROWNUM_W-1:0] y);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.mode      <= m;
    item_if.char_code <= ch;
    item_if.color     <= attr;
    item_if.column    <= x;
    item_if.row       <= y;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // wait until every result is in, then let the design idle before the next step
  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (reports_owed != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // setup and access cycle of one register write
  task automatic write_fill(logic [FILL_W-1:0] attr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FILL_ADDR;
    pwdata  <= APB_DW'(attr);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    fill_settings++;
  endtask

  // mostly text with newlines at the given rate, some cursor moves, reads and clears
  task automatic random_item(int nl_pct);
    int                  pick;
    int                  sel;
    logic [CHAR_W-1:0]   ch;
    logic [COLOR_W-1:0]  attr;
    logic [COLUMN_W-1:0] x;
    logic [ROWNUM_W-1:0] y;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    attr = COLOR_W'($urandom_range(0, 255));
    x = COLUMN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(0, COLUMNS_DEF - 1));
    y = ROWNUM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(0, ROWS_DEF - 1));
    if (sel < nl_pct) ch = CH_NEWLINE;
    else if (sel < nl_pct + 4) ch = CH_BACKSPACE;
    else ch = CHAR_W'($urandom_range(0, 255));
    if (pick < 80) send_item(MODE_PUT, ch, attr, x, y);
    else if (pick < 88) send_item(MODE_SET, ch, attr, x, y);
    else if (pick < 98) send_item(MODE_READ, ch, attr, x, y);
    else send_item(MODE_CLEAR, ch, attr, x, y);
  endtask

  // directed corners: field extremes, backspace at column 0, wrap, scroll, clamping
  task automatic directed_items();
    send_item(MODE_READ, 8'd0, 8'd0, 7'd0, 5'd0);
    send_item(MODE_PUT, 8'd65, 8'hFF, 7'd0, 5'd0);
    send_item(MODE_PUT, 8'd0, 8'h00, 7'd127, 5'd31);
    send_item(MODE_PUT, 8'd255, 8'h80, 7'd0, 5'd0);
    send_item(MODE_PUT, CH_BACKSPACE, 8'h5A, 7'd0, 5'd0);
    send_item(MODE_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    send_item(MODE_PUT, CH_BACKSPACE, 8'hA5, 7'd0, 5'd0);
    send_item(MODE_SET, 8'd0, 8'd0, 7'd127, 5'd31);
    send_item(MODE_PUT, 8'd90, 8'h1E, 7'd0, 5'd0);
    send_item(MODE_READ, 8'd0, 8'd0, 7'd79, 5'd23);
    send_item(MODE_READ, 8'd0, 8'd0, 7'd127, 5'd31);
    send_item(MODE_SET, 8'd0, 8'd0, 7'd0, 5'd24);
    send_item(MODE_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    send_item(MODE_SET, 8'd0, 8'd0, 7'd78, 5'd24);
    send_item(MODE_PUT, CH_BACKSPACE, 8'hC3, 7'd0, 5'd0);
    send_item(MODE_READ, 8'd0, 8'd0, 7'd77, 5'd24);
    send_item(MODE_SET, 8'd0, 8'd0, 7'd79, 5'd0);
    send_item(MODE_PUT, 8'd113, 8'h2C, 7'd0, 5'd0);
    send_item(MODE_READ, 8'd0, 8'd0, 7'd79, 5'd0);
    send_item(MODE_READ, 8'd0, 8'd0, 7'd0, 5'd24);
    send_item(MODE_CLEAR, 8'd0, 8'd0, 7'd0, 5'd0);
    send_item(MODE_READ, 8'd0, 8'd0, 7'd40, 5'd12);
    send_item(MODE_SET, 8'd0, 8'd0, 7'd12, 5'd7);
  endtask

  // reset, directed part, then random phases under changing fill colors
  initial begin
    item_if.valid     <= 1'b0;
    item_if.mode      <= MODE_PUT;
    item_if.char_code <= '0;
    item_if.color     <= '0;
    item_if.column    <= '0;
    item_if.row       <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    items_sent    = 0;
    fill_settings = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_items();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) write_fill('0);
      else if (p == 1) write_fill('1);
      else write_fill(FILL_W'($urandom_range(0, 127)));
      // the last phase runs without idling or stalls, some middle phases without source gaps or result stalls
      src_idle_en   = (p != PHASES - 1) && (p % 3 != 2);
      sink_stall_en = (p != PHASES - 1) && (p % 4 != 3);
      send_item(MODE_CLEAR, 8'd0, 8'd0, 7'd0, 5'd0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        random_item((p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 15));
      end
    end
    settle();

    $display("covered %0d items (puts, clears, cursor moves, reads) over %0d fill colors",
             items_sent, fill_settings);
    if (fail_count == 0 && reports_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### text_console_writer.f
design/tcw_pkg.sv
design/tcw_in_if.sv
design/tcw_out_if.sv
design/tcw_mem.sv
design/tcw_ctrl.sv
design/text_console_writer.sv
tb/tcw_screen_checker.sv
tb/text_console_writer_tb.sv
